// ===== sv/phss_pkg.sv =====
package phss_pkg;

  // Number of quotient bits produced by the divider; a percentage fits in seven.
  localparam int unsigned QUOT_BITS = 7;
  localparam int unsigned PCT_BITS  = 7;

  localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 3;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_POT_MIN       = 3'd0,
    CFG_POT_MAX       = 3'd1,
    CFG_ERROR_THR     = 3'd2,
    CFG_INACTIVE_THR  = 3'd3,
    CFG_CW_BAND_LOW   = 3'd4,
    CFG_CW_BAND_HIGH  = 3'd5,
    CFG_CCW_BAND_LOW  = 3'd6,
    CFG_CCW_BAND_HIGH = 3'd7
  } cfg_idx_t;

  // Operating mode codes.
  localparam logic [1:0] MODE_INACTIVE = 2'd0;
  localparam logic [1:0] MODE_WORK     = 2'd1;
  localparam logic [1:0] MODE_ERROR    = 2'd2;

  // Rotation direction codes.
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;
  localparam logic [1:0] DIR_BAD  = 2'd3;

  // Indicator codes.
  localparam logic [1:0] LED_WORK     = 2'd0;
  localparam logic [1:0] LED_INACTIVE = 2'd1;
  localparam logic [1:0] LED_ERROR    = 2'd2;

  // Status returned by the divider to its sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } phss_div_stat_t;

  // Eight-step half-step coil sequence.
  function automatic logic [3:0] half_step(input logic [2:0] phase);
    logic [3:0] pat;
    unique case (phase)
      3'd0: pat = 4'd1;
      3'd1: pat = 4'd3;
      3'd2: pat = 4'd2;
      3'd3: pat = 4'd6;
      3'd4: pat = 4'd4;
      3'd5: pat = 4'd12;
      3'd6: pat = 4'd8;
      3'd7: pat = 4'd9;
      default: pat = 4'd0;
    endcase
    return pat;
  endfunction

endpackage

// ===== sv/phss_div.sv =====
module phss_div #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [SAMPLE_BITS+7-1:0]            dividend,
  input  logic [SAMPLE_BITS-1:0]              divisor,
  output logic [phss_pkg::QUOT_BITS-1:0]      quotient,
  output phss_pkg::phss_div_stat_t            stat
);
  import phss_pkg::*;

  localparam int unsigned DIV_W = SAMPLE_BITS + 7;
  localparam int unsigned CNT_W = $clog2(QUOT_BITS);

  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     ds_r;
  logic [QUOT_BITS-1:0] q_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 ge;

  // One shared compare and subtract, used once per quotient bit.
  assign ge = (rem_r >= ds_r);

  // Restoring division, most significant quotient bit first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      rem_r  <= dividend;
      ds_r   <= {1'b0, divisor, {(QUOT_BITS-1){1'b0}}};
      q_r    <= '0;
      cnt_r  <= CNT_W'(QUOT_BITS - 1);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - ds_r;
      end
      ds_r <= ds_r >> 1;
      q_r  <= {q_r[QUOT_BITS-2:0], ge};
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== sv/pot_controlled_halfstep_stepper_core.sv =====
// An accepted sample passes through the scaling step, the seven passes of the
// shared divider and the decision step into the result register; the input is
// stalled until the sequencer is back in idle, so one sample is handled at a time.
// A waiting result does not block acceptance of the next sample.
// Reset (synchronous, active low) restores the register defaults, stops the
// motor and sets the anticlockwise phase to 0 and the clockwise phase to 7.
module pot_controlled_halfstep_stepper_core #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Sample channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [SAMPLE_BITS-1:0]                in_adc_sample,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [3:0]                            out_coil_pattern,
  output logic [phss_pkg::PCT_BITS-1:0]         out_percent,
  output logic [1:0]                            out_mode,
  output logic [1:0]                            out_rotation,
  output logic [1:0]                            out_led_select,
  // Configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [phss_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [SAMPLE_BITS-1:0]                cfg_data
);
  import phss_pkg::*;

  localparam int unsigned DIV_W = SAMPLE_BITS + 7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCALE,
    S_DIV,
    S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [SAMPLE_BITS-1:0] pot_min_r;
  logic [SAMPLE_BITS-1:0] pot_max_r;
  logic [PCT_BITS-1:0]    err_thr_r;
  logic [PCT_BITS-1:0]    inact_thr_r;
  logic [PCT_BITS-1:0]    cw_lo_r;
  logic [PCT_BITS-1:0]    cw_hi_r;
  logic [PCT_BITS-1:0]    ccw_lo_r;
  logic [PCT_BITS-1:0]    ccw_hi_r;

  // Motor state
  logic [1:0] rot_dir_r;
  logic [2:0] cw_phase_r;
  logic [2:0] ccw_phase_r;

  // Working registers for one sample
  logic [SAMPLE_BITS-1:0] num_r;
  logic [SAMPLE_BITS-1:0] range_r;
  logic                   empty_r;

  // Result register
  logic                   out_valid_r;
  logic [3:0]             coil_r;
  logic [PCT_BITS-1:0]    pct_out_r;
  logic [1:0]             mode_r;
  logic [1:0]             rot_out_r;
  logic [1:0]             led_r;

  logic                   in_accept;
  logic                   out_take;
  logic                   out_load;
  logic [SAMPLE_BITS-1:0] clamped;
  logic [DIV_W-1:0]       dividend;
  logic [QUOT_BITS-1:0]   quotient;
  phss_div_stat_t         div_stat;

  logic [PCT_BITS-1:0]    pct;
  logic [1:0]             mode;
  logic [1:0]             led;
  logic [1:0]             dir_nxt;
  logic [3:0]             coil;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;

  // Clamp the sample into the configured range.
  always_comb begin
    if (in_adc_sample < pot_min_r) begin
      clamped = pot_min_r;
    end else if (in_adc_sample > pot_max_r) begin
      clamped = pot_max_r;
    end else begin
      clamped = in_adc_sample;
    end
  end

  // Scaled numerator with half the range added for rounding.
  assign dividend = DIV_W'(num_r) * DIV_W'(PCT_FULL) + DIV_W'(range_r >> 1);

  phss_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_SCALE),
    .dividend (dividend),
    .divisor  (range_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Mode, direction and coil decision from the finished percentage.
  always_comb begin
    if (empty_r) begin
      pct = '0;
    end else if (quotient > PCT_FULL) begin
      pct = PCT_FULL;
    end else begin
      pct = quotient;
    end

    dir_nxt = rot_dir_r;
    priority if (pct >= err_thr_r) begin
      mode = MODE_ERROR;
      led  = LED_ERROR;
    end else if (pct <= inact_thr_r) begin
      mode = MODE_INACTIVE;
      led  = LED_INACTIVE;
    end else begin
      mode = MODE_WORK;
      led  = LED_WORK;
      priority if (cw_lo_r <= pct && pct <= cw_hi_r) begin
        dir_nxt = DIR_CW;
      end else if (ccw_lo_r <= pct && pct <= ccw_hi_r) begin
        dir_nxt = DIR_CCW;
      end else begin
        dir_nxt = DIR_STOP;
      end
    end

    unique case (dir_nxt)
      DIR_CW:  coil = half_step(cw_phase_r);
      DIR_CCW: coil = half_step(ccw_phase_r);
      default: coil = 4'd0;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pot_min_r   <= '0;
      pot_max_r   <= '1;
      err_thr_r   <= 7'd80;
      inact_thr_r <= 7'd20;
      cw_lo_r     <= 7'd30;
      cw_hi_r     <= 7'd40;
      ccw_lo_r    <= 7'd60;
      ccw_hi_r    <= 7'd70;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POT_MIN:       pot_min_r   <= cfg_data;
        CFG_POT_MAX:       pot_max_r   <= cfg_data;
        CFG_ERROR_THR:     err_thr_r   <= cfg_data[PCT_BITS-1:0];
        CFG_INACTIVE_THR:  inact_thr_r <= cfg_data[PCT_BITS-1:0];
        CFG_CW_BAND_LOW:   cw_lo_r     <= cfg_data[PCT_BITS-1:0];
        CFG_CW_BAND_HIGH:  cw_hi_r     <= cfg_data[PCT_BITS-1:0];
        CFG_CCW_BAND_LOW:  ccw_lo_r    <= cfg_data[PCT_BITS-1:0];
        CFG_CCW_BAND_HIGH: ccw_hi_r    <= cfg_data[PCT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, motor state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rot_dir_r   <= DIR_STOP;
      cw_phase_r  <= 3'd7;
      ccw_phase_r <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            num_r   <= clamped - pot_min_r;
            range_r <= pot_max_r - pot_min_r;
            empty_r <= (pot_max_r <= pot_min_r);
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            rot_dir_r <= dir_nxt;
            if (dir_nxt == DIR_CW) begin
              cw_phase_r <= cw_phase_r - 1'b1;
            end
            if (dir_nxt == DIR_CCW) begin
              ccw_phase_r <= ccw_phase_r + 1'b1;
            end
            coil_r      <= coil;
            pct_out_r   <= pct;
            mode_r      <= mode;
            rot_out_r   <= (dir_nxt == DIR_CW || dir_nxt == DIR_CCW) ? dir_nxt : DIR_STOP;
            led_r       <= led;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coil_pattern = coil_r;
  assign out_percent      = pct_out_r;
  assign out_mode         = mode_r;
  assign out_rotation     = rot_out_r;
  assign out_led_select   = led_r;

`ifndef NO_ASSERTIONS
  // The stored direction never takes the unused code.
  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    rot_dir_r != DIR_BAD)
    else $error("rotation direction holds the unused code");

  // While waiting on the divider it is either running or has just finished.
  a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("sequencer waits on an idle divider");

  // A delivered percentage never exceeds full scale.
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (pct_out_r <= PCT_FULL))
    else $error("percentage above full scale");

  // The indicator always matches the mode.
  a_led_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((mode_r == MODE_ERROR && led_r == LED_ERROR) ||
                     (mode_r == MODE_INACTIVE && led_r == LED_INACTIVE) ||
                     (mode_r == MODE_WORK && led_r == LED_WORK)))
    else $error("indicator does not match mode");

  // A stopped motor has all coils off, a turning one has some coil on.
  a_coil_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((rot_out_r == DIR_STOP) == (coil_r == 4'd0)))
    else $error("coil pattern does not match rotation");

  // An accepted sample holds off the input for the following cycle.
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("input not stalled after accepting a sample");
`endif

endmodule

// ===== test/tb_pot_controlled_halfstep_stepper_core.sv =====
module tb_pot_controlled_halfstep_stepper_core;
  timeunit 1ns;
  timeprecision 1ps;

  import phss_pkg::*;

  localparam int unsigned SB             = 12;
  localparam int unsigned CLK_HALF       = 5;
  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned NUM_PHASES     = 12;
  localparam int unsigned BUSY_ITEMS     = 165;
  localparam int unsigned DULL_ITEMS     = 40;

  // Half-step coil sequence, indexed by phase.
  localparam logic [3:0] COIL_SEQ [8] = '{4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9};

  // Idle and stall percentages, one pair per idling pattern.
  localparam int unsigned TX_IDLE  [4] = '{0, 54, 0, 32};
  localparam int unsigned RX_STALL [4] = '{0, 0, 54, 32};

  typedef enum int {
    SET_DEFAULT,
    SET_FULL_SCALE,
    SET_INVERTED,
    SET_EMPTY,
    SET_WIDE_THRESH,
    SET_ALL_ERROR,
    SET_RANDOM
  } setting_kind_t;

  localparam setting_kind_t PHASE_SETTING [NUM_PHASES] = '{
    SET_DEFAULT, SET_RANDOM, SET_FULL_SCALE, SET_RANDOM, SET_INVERTED, SET_RANDOM,
    SET_WIDE_THRESH, SET_RANDOM, SET_EMPTY, SET_RANDOM, SET_ALL_ERROR, SET_RANDOM
  };

  typedef struct packed {
    logic [3:0]          coils;
    logic [PCT_BITS-1:0] pct;
    logic [1:0]          mode;
    logic [1:0]          rot;
    logic [1:0]          led;
  } step_result_t;

  typedef struct packed {
    logic         is_cfg;
    cfg_idx_t     idx;
    logic [SB-1:0] value;
    logic         typed;
    step_result_t want;
  } plan_row_t;

  logic          clk           = 1'b0;
  logic          rst_n         = 1'b0;
  logic          in_valid      = 1'b0;
  logic          in_stall;
  logic [SB-1:0] in_adc_sample = '0;
  logic          out_valid;
  logic          out_stall     = 1'b0;
  logic [3:0]    out_coil_pattern;
  logic [PCT_BITS-1:0] out_percent;
  logic [1:0]    out_mode;
  logic [1:0]    out_rotation;
  logic [1:0]    out_led_select;
  logic          cfg_valid     = 1'b0;
  logic          cfg_ready;
  cfg_idx_t      cfg_index     = CFG_POT_MIN;
  logic [SB-1:0] cfg_data      = '0;

  // Register copies and sequencer state of the predictor.
  logic [SB-1:0]       reg_pot_min   = '0;
  logic [SB-1:0]       reg_pot_max   = '1;
  logic [PCT_BITS-1:0] reg_err_thr   = 7'd80;
  logic [PCT_BITS-1:0] reg_inact_thr = 7'd20;
  logic [PCT_BITS-1:0] reg_cw_lo     = 7'd30;
  logic [PCT_BITS-1:0] reg_cw_hi     = 7'd40;
  logic [PCT_BITS-1:0] reg_ccw_lo    = 7'd60;
  logic [PCT_BITS-1:0] reg_ccw_hi    = 7'd70;
  logic [1:0]          motor_dir     = DIR_STOP;
  logic [2:0]          ccw_phase     = 3'd0;
  logic [2:0]          cw_phase      = 3'd7;

  step_result_t expected_steps [$];
  step_result_t oldest;
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles   = 0;
  int unsigned  tx_idle_pct    = 0;
  int unsigned  rx_stall_pct   = 0;
  bit           hold_request   = 1'b0;
  plan_row_t    directed_plan [32];

  pot_controlled_halfstep_stepper_core #(.SAMPLE_BITS(SB)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_adc_sample    (in_adc_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_coil_pattern (out_coil_pattern),
    .out_percent      (out_percent),
    .out_mode         (out_mode),
    .out_rotation     (out_rotation),
    .out_led_select   (out_led_select),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Works out the result of one sample and moves the sequencer state on.
  function automatic step_result_t advance_sequencer(input logic [SB-1:0] sample);
    int unsigned  clamped;
    int unsigned  span;
    int unsigned  pct;
    step_result_t r;
    r = '0;
    if (reg_pot_max <= reg_pot_min) begin
      pct = 0;
    end else begin
      clamped = sample;
      if (clamped < reg_pot_min) begin
        clamped = reg_pot_min;
      end else if (clamped > reg_pot_max) begin
        clamped = reg_pot_max;
      end
      span = reg_pot_max - reg_pot_min;
      pct  = ((clamped - reg_pot_min) * 100 + span / 2) / span;
      if (pct > 100) begin
        pct = 100;
      end
    end
    r.pct = pct[PCT_BITS-1:0];

    // Error is tested before inactive; only work mode touches the direction.
    if (pct >= reg_err_thr) begin
      r.mode = MODE_ERROR;
      r.led  = LED_ERROR;
    end else if (pct <= reg_inact_thr) begin
      r.mode = MODE_INACTIVE;
      r.led  = LED_INACTIVE;
    end else begin
      r.mode = MODE_WORK;
      r.led  = LED_WORK;
      if (reg_cw_lo <= pct && pct <= reg_cw_hi) begin
        motor_dir = DIR_CW;
      end else if (reg_ccw_lo <= pct && pct <= reg_ccw_hi) begin
        motor_dir = DIR_CCW;
      end else begin
        motor_dir = DIR_STOP;
      end
    end

    // Each direction keeps its own phase counter.
    case (motor_dir)
      DIR_CW: begin
        r.coils  = COIL_SEQ[cw_phase];
        cw_phase = cw_phase - 3'd1;
      end
      DIR_CCW: begin
        r.coils   = COIL_SEQ[ccw_phase];
        ccw_phase = ccw_phase + 3'd1;
      end
      default: r.coils = 4'd0;
    endcase
    r.rot = (motor_dir == DIR_CW || motor_dir == DIR_CCW) ? motor_dir : DIR_STOP;
    return r;
  endfunction

  function automatic plan_row_t sample_row(input logic [SB-1:0] s);
    plan_row_t row;
    row       = '0;
    row.idx   = CFG_POT_MIN;
    row.value = s;
    return row;
  endfunction

  function automatic plan_row_t typed_row(input logic [SB-1:0] s, input logic [3:0] coils,
                                          input logic [PCT_BITS-1:0] pct, input logic [1:0] mode,
                                          input logic [1:0] rot, input logic [1:0] led);
    plan_row_t row;
    row       = sample_row(s);
    row.typed = 1'b1;
    row.want  = '{coils: coils, pct: pct, mode: mode, rot: rot, led: led};
    return row;
  endfunction

  function automatic plan_row_t reg_row(input cfg_idx_t idx, input logic [SB-1:0] v);
    plan_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.value  = v;
    return row;
  endfunction

  // Offers one sample beat, with random idle cycles ahead of it, and predicts it.
  task automatic offer_sample(input logic [SB-1:0] sample, output step_result_t predicted);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_adc_sample <= sample;
    do @(posedge clk); while (in_stall);
    predicted = advance_sequencer(sample);
  endtask

  // Stops offering samples and waits for the block to go idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [SB-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_POT_MIN:       reg_pot_min   = value;
      CFG_POT_MAX:       reg_pot_max   = value;
      CFG_ERROR_THR:     reg_err_thr   = value[PCT_BITS-1:0];
      CFG_INACTIVE_THR:  reg_inact_thr = value[PCT_BITS-1:0];
      CFG_CW_BAND_LOW:   reg_cw_lo     = value[PCT_BITS-1:0];
      CFG_CW_BAND_HIGH:  reg_cw_hi     = value[PCT_BITS-1:0];
      CFG_CCW_BAND_LOW:  reg_ccw_lo    = value[PCT_BITS-1:0];
      CFG_CCW_BAND_HIGH: reg_ccw_hi    = value[PCT_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Chooses a full register set for one phase and writes all of it.
  task automatic apply_settings(input setting_kind_t kind);
    int unsigned   lo;
    int unsigned   span;
    logic [SB-1:0] v [8];
    lo   = $urandom_range(0, 4000);
    span = ($urandom_range(1) != 0) ? $urandom_range(1, 120) : $urandom_range(1, 4095 - lo);
    if (lo + span > 4095) begin
      span = 4095 - lo;
    end
    v[CFG_POT_MIN]       = SB'(lo);
    v[CFG_POT_MAX]       = SB'(lo + span);
    v[CFG_ERROR_THR]     = 12'd80;
    v[CFG_INACTIVE_THR]  = 12'd20;
    v[CFG_CW_BAND_LOW]   = 12'd30;
    v[CFG_CW_BAND_HIGH]  = 12'd40;
    v[CFG_CCW_BAND_LOW]  = 12'd60;
    v[CFG_CCW_BAND_HIGH] = 12'd70;
    case (kind)
      SET_DEFAULT: begin
        v[CFG_POT_MIN] = 12'd0;
        v[CFG_POT_MAX] = 12'd4095;
      end
      SET_FULL_SCALE: begin
        v[CFG_POT_MIN]       = 12'd0;
        v[CFG_POT_MAX]       = 12'd4095;
        v[CFG_ERROR_THR]     = 12'd100;
        v[CFG_INACTIVE_THR]  = 12'd0;
        v[CFG_CW_BAND_LOW]   = 12'd1;
        v[CFG_CW_BAND_HIGH]  = 12'd49;
        v[CFG_CCW_BAND_LOW]  = 12'd51;
        v[CFG_CCW_BAND_HIGH] = 12'd99;
      end
      SET_INVERTED: begin
        v[CFG_POT_MIN] = 12'd4095;
        v[CFG_POT_MAX] = 12'd0;
      end
      SET_EMPTY: v[CFG_POT_MAX] = v[CFG_POT_MIN];
      SET_WIDE_THRESH: begin
        // Thresholds beyond a hundred, with bands that may overlap.
        v[CFG_ERROR_THR]     = 12'hFFF;
        v[CFG_INACTIVE_THR]  = 12'd0;
        v[CFG_CW_BAND_LOW]   = SB'($urandom_range(0, 50));
        v[CFG_CW_BAND_HIGH]  = SB'($urandom_range(v[CFG_CW_BAND_LOW], 127));
        v[CFG_CCW_BAND_LOW]  = SB'($urandom_range(0, 100));
        v[CFG_CCW_BAND_HIGH] = SB'($urandom_range(v[CFG_CCW_BAND_LOW], 127));
      end
      SET_ALL_ERROR: v[CFG_ERROR_THR] = 12'd0;
      default: begin
        v[CFG_INACTIVE_THR]  = SB'($urandom_range(0, 35));
        v[CFG_ERROR_THR]     = SB'($urandom_range(65, 101));
        v[CFG_CW_BAND_LOW]   = SB'($urandom_range(v[CFG_INACTIVE_THR], 55));
        v[CFG_CW_BAND_HIGH]  = SB'($urandom_range(v[CFG_CW_BAND_LOW], 70));
        v[CFG_CCW_BAND_LOW]  = SB'($urandom_range(35, 90));
        v[CFG_CCW_BAND_HIGH] = SB'($urandom_range(v[CFG_CCW_BAND_LOW], 100));
        // The upper data bits of a percentage register must be dropped.
        for (int k = 2; k < 8; k++) begin
          v[k] = v[k] | SB'($urandom_range(0, 31) << PCT_BITS);
        end
      end
    endcase
    for (int k = 0; k < 8; k++) begin
      write_reg(cfg_idx_t'(k), v[k]);
    end
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Every result beat is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_steps.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, actual coils %0d percent %0d",
                 $time, out_coil_pattern, out_percent);
        mismatch_count++;
      end else begin
        oldest = expected_steps.pop_front();
        check_field("coil_pattern", oldest.coils, out_coil_pattern);
        check_field("percent", oldest.pct, out_percent);
        check_field("mode", oldest.mode, out_mode);
        check_field("rotation", oldest.rot, out_rotation);
        check_field("led_select", oldest.led, out_led_select);
      end
    end
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    step_result_t  predicted;
    int unsigned   sample;
    int unsigned   n_items;
    int unsigned   ph;
    int unsigned   i;

    // Directed part: extremes, band edges, mode boundaries and the odd ranges.
    directed_plan = '{
      typed_row(12'd0, 4'd0, 7'd0, MODE_INACTIVE, DIR_STOP, LED_INACTIVE),
      typed_row(12'd4095, 4'd0, 7'd100, MODE_ERROR, DIR_STOP, LED_ERROR),
      typed_row(12'd1433, 4'd9, 7'd35, MODE_WORK, DIR_CW, LED_WORK),
      sample_row(12'd1228),
      sample_row(12'd1638),
      sample_row(12'd4095),
      sample_row(12'd819),
      sample_row(12'd2662),
      sample_row(12'd2457),
      sample_row(12'd2866),
      sample_row(12'd2048),
      sample_row(12'hAAA),
      sample_row(12'h555),
      // Inverted range, then an empty one: the percentage must read zero.
      reg_row(CFG_POT_MIN, 12'd2000),
      reg_row(CFG_POT_MAX, 12'd1000),
      sample_row(12'd3000),
      reg_row(CFG_POT_MAX, 12'd2000),
      sample_row(12'd2000),
      // Narrow range with samples either side of it.
      reg_row(CFG_POT_MIN, 12'd100),
      reg_row(CFG_POT_MAX, 12'd200),
      sample_row(12'd50),
      sample_row(12'd4095),
      sample_row(12'd150),
      // Thresholds above a hundred and overlapping bands.
      reg_row(CFG_ERROR_THR, 12'hFFF),
      reg_row(CFG_INACTIVE_THR, 12'd0),
      reg_row(CFG_CW_BAND_LOW, 12'd90),
      reg_row(CFG_CW_BAND_HIGH, 12'd110),
      reg_row(CFG_CCW_BAND_LOW, 12'd95),
      reg_row(CFG_CCW_BAND_HIGH, 12'h07F),
      sample_row(12'd4095),
      sample_row(12'd100),
      sample_row(12'd195)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[r]) begin
      if (directed_plan[r].is_cfg) begin
        settle();
        write_reg(directed_plan[r].idx, directed_plan[r].value);
      end else begin
        offer_sample(directed_plan[r].value, predicted);
        expected_steps.push_back(directed_plan[r].typed ? directed_plan[r].want : predicted);
      end
    end

    // Random part: one register set and one idling pattern per phase.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      apply_settings(PHASE_SETTING[ph]);
      tx_idle_pct  = TX_IDLE[ph % 4];
      rx_stall_pct = RX_STALL[ph % 4];
      n_items = (PHASE_SETTING[ph] == SET_INVERTED || PHASE_SETTING[ph] == SET_EMPTY ||
                 PHASE_SETTING[ph] == SET_ALL_ERROR) ? DULL_ITEMS : BUSY_ITEMS;
      for (i = 0; i < n_items; i++) begin
        // Hold the result side off while samples keep coming, so the block backs up.
        if (ph == 0 && i == 30) begin
          hold_request = 1'b1;
        end
        // Mostly samples inside the range so the bands are hit; some anywhere.
        if ($urandom_range(9) < 7 && reg_pot_max > reg_pot_min) begin
          sample = $urandom_range(reg_pot_min, reg_pot_max);
        end else begin
          sample = $urandom_range(0, 4095);
        end
        offer_sample(sample[SB-1:0], predicted);
        expected_steps.push_back(predicted);
      end
    end

    settle();
    if (mismatch_count == 0 && expected_steps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
